// File: design/limit_order_book_matcher_unit_macros.svh
// assertion macros for the limit order book matcher
// expects clk_i and rst_ni in the scope of each use
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`ifndef SYNTH
`define LOBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lobm assertion failed");
`define LOBM_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("lobm forbidden condition");
`else
`define LOBM_ASSERT(lbl, prop)
`define LOBM_NEVER(lbl, expr)
`endif
`endif

// File: design/lobm_pkg.sv
// shared types and constants of the limit order book matcher
// no dependencies
`timescale 1ns / 1ps
package lobm_pkg;

  localparam int ORDER_SLOTS = 32;
  localparam int SLOT_W      = $clog2(ORDER_SLOTS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int VOL_W       = 24;
  localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_SUBMIT = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_TRADE  = 2'd0,
    KIND_SUBMIT = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_VOLUME = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic             side;
    logic [15:0]      client;
    logic [31:0]      ord_ref;
    logic [15:0]      limit_price;
    logic [VOL_W-1:0] order_volume;
  } lobm_req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [15:0]      buyer;
    logic [15:0]      seller;
    logic [15:0]      trade_price;
    logic [VOL_W-1:0] amount;
    logic             last;
  } lobm_res_t;

endpackage

// File: design/lobm_front.sv
// request front end: takes items, drops REQ_NONE items, queues the rest
// depends on lobm_pkg
`timescale 1ns / 1ps
module lobm_front import lobm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  lobm_req_t req_i,
  output logic      q_valid_o,
  output lobm_req_t q_data_o,
  input  logic      q_pop_i
);

  lobm_req_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              accept, push;

  // accept whenever a queue entry is free; REQ_NONE items are consumed here
  assign busy      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign accept    = start && !busy;
  assign push      = accept && (req_i.req_type != REQ_NONE);
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_i;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: design/lobm_engine.sv
// matching engine: slot store, scan sequencer and result register
// depends on lobm_pkg and the macros header
`timescale 1ns / 1ps
`include "limit_order_book_matcher_unit_macros.svh"
module lobm_engine import lobm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  lobm_req_t q_data_i,
  output logic      q_pop_o,
  output logic      res_strobe_o,
  output lobm_res_t res_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_FILL = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  // slot store
  logic             slot_valid_q [ORDER_SLOTS];
  logic             slot_side_q  [ORDER_SLOTS];
  logic [15:0]      slot_client_q[ORDER_SLOTS];
  logic [31:0]      slot_oid_q   [ORDER_SLOTS];
  logic [15:0]      slot_price_q [ORDER_SLOTS];
  logic [VOL_W-1:0] slot_vol_q   [ORDER_SLOTS];
  logic [31:0]      slot_arr_q   [ORDER_SLOTS];

  state_e           state_q, state_d;
  lobm_req_t        cur_q;
  logic [VOL_W-1:0] rem_q, rem_d;
  logic [SLOT_W-1:0] scan_q;
  logic             best_vld_q;
  logic [SLOT_W-1:0] best_idx_q;
  logic [15:0]      best_price_q, best_cli_q;
  logic [31:0]      best_arr_q;
  logic [VOL_W-1:0] best_vol_q;
  logic             free_vld_q;
  logic [SLOT_W-1:0] free_idx_q;
  logic [VOL_W-1:0] sum_q;
  logic [1:0]       done_status_q, done_status_d;
  logic [VOL_W-1:0] done_amt_q, done_amt_d;
  logic [31:0]      arrival_q;
  logic             res_strobe_q;
  lobm_res_t        res_q, res_d;
  logic             res_strobe_d;

  // current scanned slot
  logic             s_vld, s_side;
  logic [15:0]      s_price, s_cli;
  logic [31:0]      s_oid, s_arr;
  logic [VOL_W-1:0] s_vol;
  logic             opp, take, better, cand;
  logic [VOL_W:0]   sum_ext;
  logic             crossing;
  logic [VOL_W-1:0] traded, left_vol;
  logic             start_scan, rest_we, fill_we, cancel_hit;

  assign s_vld   = slot_valid_q[scan_q];
  assign s_side  = slot_side_q[scan_q];
  assign s_price = slot_price_q[scan_q];
  assign s_cli   = slot_client_q[scan_q];
  assign s_oid   = slot_oid_q[scan_q];
  assign s_arr   = slot_arr_q[scan_q];
  assign s_vol   = slot_vol_q[scan_q];
  assign opp     = ~cur_q.side;

  // per-slot compare for the running scan
  always_comb begin
    cand   = 1'b0;
    better = 1'b0;
    case (req_e'(cur_q.req_type))
      REQ_SUBMIT: begin
        cand = s_vld && (s_side == opp);
        if (s_price != best_price_q) begin
          better = (opp == SIDE_SELL) ? (s_price < best_price_q) : (s_price > best_price_q);
        end else begin
          better = s_arr < best_arr_q;
        end
      end
      REQ_CANCEL: begin
        cand   = s_vld && (s_side == cur_q.side) && (s_cli == cur_q.client)
                 && (s_oid == cur_q.ord_ref);
        better = s_arr >= best_arr_q;
      end
      default: begin
        cand   = 1'b0;
        better = 1'b0;
      end
    endcase
  end
  assign take    = cand && (!best_vld_q || better);
  assign sum_ext = {1'b0, sum_q} + {1'b0, s_vol};

  // fill arithmetic
  assign crossing = (cur_q.side == SIDE_BUY) ? (best_price_q <= cur_q.limit_price)
                                             : (best_price_q >= cur_q.limit_price);
  assign traded   = (rem_q < best_vol_q) ? rem_q : best_vol_q;
  assign left_vol = best_vol_q - traded;

  // sequencer
  always_comb begin
    state_d       = state_q;
    rem_d         = rem_q;
    done_status_d = done_status_q;
    done_amt_d    = done_amt_q;
    res_strobe_d  = 1'b0;
    res_d         = res_q;
    q_pop_o       = 1'b0;
    start_scan    = 1'b0;
    rest_we       = 1'b0;
    fill_we       = 1'b0;
    cancel_hit    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o       = 1'b1;
          rem_d         = q_data_i.order_volume;
          done_status_d = ST_OK;
          done_amt_d    = '0;
          start_scan    = 1'b1;
          if ((req_e'(q_data_i.req_type) == REQ_SUBMIT) && (q_data_i.order_volume == '0)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_q == SLOT_W'(ORDER_SLOTS - 1)) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_DONE;
        case (req_e'(cur_q.req_type))
          REQ_SUBMIT: begin
            if (best_vld_q && crossing) begin
              state_d = ST_FILL;
            end else if (free_vld_q) begin
              rest_we       = 1'b1;
              done_status_d = ST_OK;
              done_amt_d    = rem_q;
            end else begin
              done_status_d = ST_FULL;
              done_amt_d    = rem_q;
            end
          end
          REQ_CANCEL: begin
            cancel_hit    = best_vld_q;
            done_status_d = best_vld_q ? ST_OK : ST_NOTFOUND;
            done_amt_d    = best_vld_q ? best_vol_q : '0;
          end
          default: begin
            done_status_d = ST_OK;
            done_amt_d    = sum_q;
          end
        endcase
      end
      ST_FILL: begin
        fill_we            = 1'b1;
        rem_d              = rem_q - traded;
        res_strobe_d       = 1'b1;
        res_d.kind         = KIND_TRADE;
        res_d.status       = ST_OK;
        res_d.buyer        = (cur_q.side == SIDE_BUY) ? cur_q.client : best_cli_q;
        res_d.seller       = (cur_q.side == SIDE_BUY) ? best_cli_q : cur_q.client;
        res_d.trade_price  = best_price_q;
        res_d.amount       = traded;
        res_d.last         = 1'b0;
        if (rem_q == traded) begin
          done_status_d = ST_OK;
          done_amt_d    = '0;
          state_d       = ST_DONE;
        end else begin
          start_scan = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_DONE: begin
        res_strobe_d      = 1'b1;
        res_d.status      = done_status_q;
        res_d.buyer       = '0;
        res_d.seller      = '0;
        res_d.trade_price = '0;
        res_d.amount      = done_amt_q;
        res_d.last        = 1'b1;
        case (req_e'(cur_q.req_type))
          REQ_SUBMIT: res_d.kind = KIND_SUBMIT;
          REQ_CANCEL: res_d.kind = KIND_CANCEL;
          default:    res_d.kind = KIND_VOLUME;
        endcase
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      res_strobe_q <= 1'b0;
      arrival_q    <= '0;
      best_vld_q   <= 1'b0;
      free_vld_q   <= 1'b0;
      scan_q       <= '0;
    end else begin
      state_q      <= state_d;
      res_strobe_q <= res_strobe_d;
      if (rest_we) begin
        arrival_q <= arrival_q + 1'b1;
      end
      if (start_scan) begin
        best_vld_q <= 1'b0;
        free_vld_q <= 1'b0;
        scan_q     <= '0;
      end else if (state_q == ST_SCAN) begin
        scan_q <= scan_q + 1'b1;
        if (take) begin
          best_vld_q <= 1'b1;
        end
        if (!s_vld && !free_vld_q) begin
          free_vld_q <= 1'b1;
        end
      end
    end
  end

  // valid bits of the slot store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        slot_valid_q[i] <= 1'b0;
      end
    end else begin
      if (rest_we) begin
        slot_valid_q[free_idx_q] <= 1'b1;
      end
      if (fill_we && (left_vol == '0)) begin
        slot_valid_q[best_idx_q] <= 1'b0;
      end
      if (cancel_hit) begin
        slot_valid_q[best_idx_q] <= 1'b0;
      end
    end
  end

  // slot payload writes
  always_ff @(posedge clk_i) begin
    if (rest_we) begin
      slot_side_q[free_idx_q]   <= cur_q.side;
      slot_client_q[free_idx_q] <= cur_q.client;
      slot_oid_q[free_idx_q]    <= cur_q.ord_ref;
      slot_price_q[free_idx_q]  <= cur_q.limit_price;
      slot_vol_q[free_idx_q]    <= rem_q;
      slot_arr_q[free_idx_q]    <= arrival_q;
    end else if (fill_we) begin
      slot_vol_q[best_idx_q] <= left_vol;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q         <= rem_d;
    done_status_q <= done_status_d;
    done_amt_q    <= done_amt_d;
    res_q         <= res_d;
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
    if (start_scan) begin
      sum_q <= '0;
    end else if (state_q == ST_SCAN) begin
      if (take) begin
        best_idx_q   <= scan_q;
        best_price_q <= s_price;
        best_cli_q   <= s_cli;
        best_arr_q   <= s_arr;
        best_vol_q   <= s_vol;
      end
      if (!s_vld && !free_vld_q) begin
        free_idx_q <= scan_q;
      end
      if (s_vld && (s_side == cur_q.side) && (s_price == cur_q.limit_price)) begin
        sum_q <= sum_ext[VOL_W] ? VOL_MAX : sum_ext[VOL_W-1:0];
      end
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  // checks
  `LOBM_ASSERT(a_fill_has_best, (state_q == ST_FILL) |-> best_vld_q)
  `LOBM_ASSERT(a_submit_scan_rem,
    ((state_q == ST_SCAN) && (req_e'(cur_q.req_type) == REQ_SUBMIT)) |-> (rem_q != '0))
  `LOBM_NEVER(a_trade_last, res_strobe_q && (kind_e'(res_q.kind) == KIND_TRADE) && res_q.last)
  `LOBM_ASSERT(a_status_spacing, (res_strobe_q && res_q.last) |=> !(res_strobe_q && res_q.last))

endmodule

// File: design/limit_order_book_matcher_unit.sv
// top level of the limit order book matcher: front end queue and matching engine
// depends on lobm_pkg, lobm_front and lobm_engine
`timescale 1ns / 1ps
// Price-time priority order book with ORDER_SLOTS resting orders. A request is
// taken when start is high and busy is low; up to two requests queue ahead of
// the engine. Every result sits on res_o for one cycle with res_strobe_o high
// and must be taken then, since there is no way to stall the block. The engine
// scans the slot store one slot per cycle: a cancel or query makes one full scan,
// and a submit makes a full scan before each fill and, unless its last fill
// completes it, one more scan before it rests or reports a full book.
// A submit yields its trades followed by one status item with last set.
module limit_order_book_matcher_unit import lobm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  lobm_req_t req_i,
  output logic      res_strobe_o,
  output lobm_res_t res_o
);

  logic      q_valid, q_pop;
  lobm_req_t q_data;

  // front end with request queue
  lobm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  // matching engine
  lobm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule
